FILE: hdl/bsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_pkg: shared constants for the barometer compensation block
// Field widths, calibration register indexes and the fixed points of the
// second-order correction.
// ----------------------------------------------------------------------------
package bsc_pkg;

	localparam int RAW_W  = 24;
	localparam int ADC_BITS = 24;
	localparam int CAL_W  = 16;
	localparam int OUT_W  = 32;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_SENS_BASE        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BASE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMP_COEF   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP_COEF = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_SENS        = 3'd5;

	localparam int N_STAGES = 10;

	localparam int DT_W   = CAL_W + 8 + 2;
	localparam int MUL_W  = DT_W + CAL_W + 1;
	localparam int MDD_W  = 2 * DT_W;
	localparam int TD_W   = MUL_W - 23 + 1;
	localparam int T2_W   = MDD_W - 31;
	localparam int TEMP_W = TD_W + 2;
	localparam int SQ_W   = 2 * TD_W;
	localparam int OFF_W  = 42;
	localparam int SENS_W = 40;
	localparam int HALF_W = SENS_W / 2;
	localparam int PLO_W  = ADC_BITS + HALF_W;
	localparam int PHI_W  = ADC_BITS + 1 + HALF_W;
	localparam int PROD_W = 64;

	localparam logic signed [TD_W-1:0] TEMP_REF   = TD_W'(2000);
	localparam logic signed [TD_W-1:0] FRIGID_REF = TD_W'(2000 + 1500);

	localparam logic signed [OUT_W-1:0] P_LOW  = 32'sd10000;
	localparam logic signed [OUT_W-1:0] P_HIGH = 32'sd120000;

endpackage

`default_nettype wire

FILE: hdl/bsc_sample_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_sample_if: raw conversion channel
// Carries one raw pressure and one raw temperature conversion per transaction.
// ----------------------------------------------------------------------------
interface bsc_sample_if;

	logic                        valid;
	logic                        ready;
	logic [bsc_pkg::RAW_W-1:0]   pressure_raw;
	logic [bsc_pkg::RAW_W-1:0]   temp_raw;

	modport source (output valid, output pressure_raw, output temp_raw, input ready);
	modport sink   (input valid, input pressure_raw, input temp_raw, output ready);

endinterface

`default_nettype wire

FILE: hdl/bsc_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_result_if: compensated result channel
// Carries temperature, pressure and the range flag per transaction.
// ----------------------------------------------------------------------------
interface bsc_result_if;

	logic                              valid;
	logic                              ready;
	logic signed [bsc_pkg::OUT_W-1:0]  temp_centideg;
	logic signed [bsc_pkg::OUT_W-1:0]  pressure_pa;
	logic                              in_range;

	modport source (output valid, output temp_centideg, output pressure_pa,
		output in_range, input ready);
	modport sink   (input valid, input temp_centideg, input pressure_pa,
		input in_range, output ready);

endinterface

`default_nettype wire

FILE: hdl/baro_sensor_compensation.sv
`default_nettype none
// ----------------------------------------------------------------------------
// baro_sensor_compensation: second-order barometer compensation pipeline
//
//   channel   dir   handshake        payload
//   sample    in    valid/ready      pressure_raw, temp_raw
//   result    out   valid/ready      temp_centideg, pressure_pa, in_range
//   cfg       in    cfg_we           cfg_idx, cfg_wdata
//
// Ten register stages, s1 to s10; a transaction accepted into s1 leaves from s10,
// and one enters every cycle unless a stalled result channel fills the pipeline.
// The multiplier stages set the depth; the 24x40 pressure product is split
// into two partial products in one stage and summed in the next.
// Reset clears the stage valid bits and the six calibration registers.
// A stalled stage holds its transaction while empty stages upstream keep filling.
// ----------------------------------------------------------------------------
module baro_sensor_compensation (
	input  wire                              clk,
	input  wire                              arst_n,
	bsc_sample_if.sink                       sample,
	bsc_result_if.source                     result,
	input  wire                              cfg_we,
	input  wire [bsc_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire [bsc_pkg::CAL_W-1:0]         cfg_wdata
);

	localparam int N = bsc_pkg::N_STAGES;

	logic [bsc_pkg::CAL_W-1:0] sens_base_q;
	logic [bsc_pkg::CAL_W-1:0] offset_base_q;
	logic [bsc_pkg::CAL_W-1:0] sens_temp_coef_q;
	logic [bsc_pkg::CAL_W-1:0] offset_temp_coef_q;
	logic [bsc_pkg::CAL_W-1:0] ref_temp_q;
	logic [bsc_pkg::CAL_W-1:0] temp_sens_q;

	logic [N:1] vld_q;
	logic [N:1] adv;

	logic [bsc_pkg::ADC_BITS-1:0]     d1_s1, d1_s2, d1_s3, d1_s4, d1_s5, d1_s6;
	logic signed [bsc_pkg::DT_W-1:0]  dt_s1;
	logic signed [bsc_pkg::MUL_W-1:0] mt_s2, mo_s2, ms_s2;
	logic [bsc_pkg::MDD_W-1:0]        mdd_s2;
	logic signed [bsc_pkg::TD_W-1:0]  td_s3, td2_s3, temp_s3;
	logic [bsc_pkg::T2_W-1:0]         t2_s3;
	logic [bsc_pkg::OFF_W-1:0]        off_s3, off_s4, off_s5, off_s6, off_s7, off_s8;
	logic [bsc_pkg::SENS_W-1:0]       sens_s3, sens_s4, sens_s5, sens_s6;
	logic [bsc_pkg::SQ_W-1:0]         sq_s4, sq2_s4;
	logic                             cold_s4, frigid_s4;
	logic signed [bsc_pkg::TEMP_W-1:0] tmp_s4, tmp_s5, tmp_s6, tmp_s7, tmp_s8, tmp_s9;
	logic [bsc_pkg::OFF_W-1:0]        off2_s5;
	logic [bsc_pkg::SENS_W-1:0]       sens2_s5;
	logic [bsc_pkg::PLO_W-1:0]        pplo_s7;
	logic signed [bsc_pkg::PHI_W-1:0] pphi_s7;
	logic [bsc_pkg::PROD_W-1:0]       prod_s8;
	logic [bsc_pkg::OUT_W-1:0]        p_s9;
	logic signed [bsc_pkg::OUT_W-1:0] temp_s10, pres_s10;
	logic                             rng_s10;

	logic [bsc_pkg::DT_W-1:0]         d2_ext, c4_ext, dt_c;
	logic signed [bsc_pkg::TD_W-1:0]  td_c;
	logic [bsc_pkg::SQ_W+1:0]         five_sq;
	logic [bsc_pkg::SQ_W+3:0]         seven_sq2, eleven_sq2;
	logic [bsc_pkg::PROD_W-1:0]       diff_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_base_q        <= '0;
			offset_base_q      <= '0;
			sens_temp_coef_q   <= '0;
			offset_temp_coef_q <= '0;
			ref_temp_q         <= '0;
			temp_sens_q        <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				bsc_pkg::REG_SENS_BASE:        sens_base_q        <= cfg_wdata;
				bsc_pkg::REG_OFFSET_BASE:      offset_base_q      <= cfg_wdata;
				bsc_pkg::REG_SENS_TEMP_COEF:   sens_temp_coef_q   <= cfg_wdata;
				bsc_pkg::REG_OFFSET_TEMP_COEF: offset_temp_coef_q <= cfg_wdata;
				bsc_pkg::REG_REF_TEMP:         ref_temp_q         <= cfg_wdata;
				bsc_pkg::REG_TEMP_SENS:        temp_sens_q        <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// A stage may load when it is empty or when its content moves on.
	always_comb begin
		adv[N] = !vld_q[N] || result.ready;
		for (int k = N - 1; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= sample.valid;
			end
			for (int k = 2; k <= N; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign sample.ready = adv[1];

	assign d2_ext = {{(bsc_pkg::DT_W-bsc_pkg::ADC_BITS){1'b0}},
		sample.temp_raw[bsc_pkg::ADC_BITS-1:0]};
	assign c4_ext = {{(bsc_pkg::DT_W-bsc_pkg::CAL_W-8){1'b0}}, ref_temp_q, 8'h00};
	assign dt_c   = d2_ext - c4_ext;

	assign td_c = {mt_s2[bsc_pkg::MUL_W-1], mt_s2[bsc_pkg::MUL_W-1:23]};

	assign five_sq    = {sq_s4, 2'b00} + {2'b00, sq_s4};
	assign seven_sq2  = {1'b0, sq2_s4, 3'b000} - {4'h0, sq2_s4};
	assign eleven_sq2 = {1'b0, sq2_s4, 3'b000} + {3'b000, sq2_s4, 1'b0} + {4'h0, sq2_s4};

	assign diff_c = {{21{prod_s8[bsc_pkg::PROD_W-1]}}, prod_s8[bsc_pkg::PROD_W-1:21]}
		- {{(bsc_pkg::PROD_W-bsc_pkg::OFF_W){off_s8[bsc_pkg::OFF_W-1]}}, off_s8};

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			d1_s1 <= sample.pressure_raw[bsc_pkg::ADC_BITS-1:0];
			dt_s1 <= $signed(dt_c);
		end
		if (adv[2]) begin
			d1_s2  <= d1_s1;
			mt_s2  <= dt_s1 * $signed({1'b0, temp_sens_q});
			mo_s2  <= dt_s1 * $signed({1'b0, offset_temp_coef_q});
			ms_s2  <= dt_s1 * $signed({1'b0, sens_temp_coef_q});
			mdd_s2 <= dt_s1 * dt_s1;
		end
		if (adv[3]) begin
			d1_s3   <= d1_s2;
			td_s3   <= td_c;
			td2_s3  <= td_c + bsc_pkg::FRIGID_REF;
			temp_s3 <= td_c + bsc_pkg::TEMP_REF;
			t2_s3   <= mdd_s2[bsc_pkg::MDD_W-1:31];
			off_s3  <= bsc_pkg::OFF_W'({offset_base_q, 16'h0000})
				+ bsc_pkg::OFF_W'(mo_s2 >>> 7);
			sens_s3 <= bsc_pkg::SENS_W'({sens_base_q, 15'h0000})
				+ bsc_pkg::SENS_W'(ms_s2 >>> 8);
		end
		if (adv[4]) begin
			d1_s4     <= d1_s3;
			off_s4    <= off_s3;
			sens_s4   <= sens_s3;
			cold_s4   <= td_s3[bsc_pkg::TD_W-1];
			frigid_s4 <= td2_s3[bsc_pkg::TD_W-1];
			sq_s4     <= td_s3 * td_s3;
			sq2_s4    <= td2_s3 * td2_s3;
			if (td_s3[bsc_pkg::TD_W-1]) begin
				tmp_s4 <= $signed({{2{temp_s3[bsc_pkg::TD_W-1]}}, temp_s3})
					- $signed({2'b00, t2_s3});
			end else begin
				tmp_s4 <= $signed({{2{temp_s3[bsc_pkg::TD_W-1]}}, temp_s3});
			end
		end
		if (adv[5]) begin
			d1_s5   <= d1_s4;
			off_s5  <= off_s4;
			sens_s5 <= sens_s4;
			tmp_s5  <= tmp_s4;
			if (!cold_s4) begin
				off2_s5  <= '0;
				sens2_s5 <= '0;
			end else if (frigid_s4) begin
				off2_s5  <= bsc_pkg::OFF_W'(five_sq >> 1) + bsc_pkg::OFF_W'(seven_sq2);
				sens2_s5 <= bsc_pkg::SENS_W'(five_sq >> 2)
					+ bsc_pkg::SENS_W'(eleven_sq2 >> 1);
			end else begin
				off2_s5  <= bsc_pkg::OFF_W'(five_sq >> 1);
				sens2_s5 <= bsc_pkg::SENS_W'(five_sq >> 2);
			end
		end
		if (adv[6]) begin
			d1_s6   <= d1_s5;
			tmp_s6  <= tmp_s5;
			off_s6  <= off_s5 - off2_s5;
			sens_s6 <= sens_s5 - sens2_s5;
		end
		if (adv[7]) begin
			tmp_s7  <= tmp_s6;
			off_s7  <= off_s6;
			pplo_s7 <= d1_s6 * sens_s6[bsc_pkg::HALF_W-1:0];
			pphi_s7 <= $signed({1'b0, d1_s6}) * $signed(sens_s6[bsc_pkg::SENS_W-1:bsc_pkg::HALF_W]);
		end
		if (adv[8]) begin
			tmp_s8  <= tmp_s7;
			off_s8  <= off_s7;
			prod_s8 <= bsc_pkg::PROD_W'($signed({pphi_s7, {bsc_pkg::HALF_W{1'b0}}}))
				+ {{(bsc_pkg::PROD_W-bsc_pkg::PLO_W){1'b0}}, pplo_s7};
		end
		if (adv[9]) begin
			tmp_s9 <= tmp_s8;
			p_s9   <= diff_c[bsc_pkg::OUT_W+14:15];
		end
		if (adv[10]) begin
			temp_s10 <= bsc_pkg::OUT_W'(tmp_s9);
			pres_s10 <= $signed(p_s9);
			rng_s10  <= ($signed(p_s9) > bsc_pkg::P_LOW) && ($signed(p_s9) < bsc_pkg::P_HIGH);
		end
	end

	assign result.valid         = vld_q[N];
	assign result.temp_centideg = temp_s10;
	assign result.pressure_pa   = pres_s10;
	assign result.in_range      = rng_s10;

`ifndef SYNTH
	// Back-pressure reaches the input only when every stage is full.
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> ((&vld_q) && !result.ready))
		else $error("input blocked while the pipeline has room");

	// A stage that cannot advance keeps its transaction.
	a_stall_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(|(vld_q & ~adv)) |=> ((vld_q & $past(vld_q & ~adv)) == $past(vld_q & ~adv)))
		else $error("stalled stage lost its transaction");

	// The extra low-temperature terms only apply inside the cold range.
	a_frigid_is_cold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[4] && frigid_s4) |-> cold_s4)
		else $error("low-temperature flags disagree");
`endif

endmodule

`default_nettype wire
